>>> design/pbs_pkg.sv
// Shared constants, types and codes of the proportional bar smoother.
package pbs_pkg;

  localparam int SEGMENTS   = 5;
  localparam int WIDTH_BITS = 10;
  localparam int COUNT_BITS = 8;
  localparam int SEG_W      = $clog2(SEGMENTS);
  localparam int TOTAL_W    = COUNT_BITS + $clog2(SEGMENTS);
  localparam int PROD_W     = COUNT_BITS + WIDTH_BITS;
  localparam int PADDR_W    = 3;
  localparam int APB_DATA_W = 32;

  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam width_t BAR_RESET = WIDTH_BITS'(400);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic {
    REG_BAR_WIDTH = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_LAST,
    ST_TICK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    width_t bar_width;
    logic   reinit;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> design/pbs_ifs.sv
// Valid/ready channel interfaces for samples/ticks and for shown widths.
interface pbs_in_if;
  logic             valid;
  logic             ready;
  logic             op;
  pbs_pkg::count_t  count_user;
  pbs_pkg::count_t  count_nice;
  pbs_pkg::count_t  count_sys;
  pbs_pkg::count_t  count_queue;
  pbs_pkg::count_t  count_idle;

  modport source (
    output valid, op, count_user, count_nice, count_sys, count_queue, count_idle,
    input  ready
  );
  modport sink (
    input  valid, op, count_user, count_nice, count_sys, count_queue, count_idle,
    output ready
  );
endinterface

interface pbs_out_if;
  logic             valid;
  logic             ready;
  pbs_pkg::width_t  shown_user;
  pbs_pkg::width_t  shown_nice;
  pbs_pkg::width_t  shown_sys;
  pbs_pkg::width_t  shown_queue;
  pbs_pkg::width_t  shown_idle;

  modport source (
    output valid, shown_user, shown_nice, shown_sys, shown_queue, shown_idle,
    input  ready
  );
  modport sink (
    input  valid, shown_user, shown_nice, shown_sys, shown_queue, shown_idle,
    output ready
  );
endinterface

>>> design/pbs_div_serial.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module pbs_div_serial (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pbs_pkg::PROD_W-1:0]          dividend_i,
  input  logic [pbs_pkg::TOTAL_W-1:0]         divisor_i,
  output pbs_pkg::div_stat_t                  stat_o,
  output pbs_pkg::width_t                     quotient_o
);

  localparam int CNT_W = $clog2(pbs_pkg::WIDTH_BITS + 1);

  logic [pbs_pkg::TOTAL_W-1:0] rem_q, rem_d, div_q, div_d;
  pbs_pkg::width_t             sh_q, sh_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;
  logic [pbs_pkg::TOTAL_W:0]   trial;
  logic [pbs_pkg::TOTAL_W:0]   diff;
  logic                        fits;

  // The quotient fits in WIDTH_BITS, so the high part of the dividend
  // seeds the remainder and only the low bits are shifted in.
  always_comb begin
    trial  = {rem_q, sh_q[pbs_pkg::WIDTH_BITS-1]};
    diff   = trial - {1'b0, div_q};
    fits   = trial >= {1'b0, div_q};
    rem_d  = rem_q;
    div_d  = div_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = pbs_pkg::TOTAL_W'(dividend_i[pbs_pkg::PROD_W-1:pbs_pkg::WIDTH_BITS]);
      sh_d   = dividend_i[pbs_pkg::WIDTH_BITS-1:0];
      div_d  = divisor_i;
      cnt_d  = CNT_W'(pbs_pkg::WIDTH_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[pbs_pkg::TOTAL_W-1:0] : trial[pbs_pkg::TOTAL_W-1:0];
      sh_d  = {sh_q[pbs_pkg::WIDTH_BITS-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    sh_q  <= sh_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = sh_q;

endmodule

>>> design/pbs_apb_regs.sv
// APB register file holding the bar width.
module pbs_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pbs_pkg::PADDR_W-1:0]        paddr,
  input  logic [pbs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pbs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output pbs_pkg::cfg_t                      cfg_o
);

  pbs_pkg::reg_idx_e idx;
  logic              hit;
  pbs_pkg::width_t   bar_q;
  logic              reinit_q;

  assign idx    = pbs_pkg::reg_idx_e'(paddr[pbs_pkg::PADDR_W-1]);
  assign hit    = psel && penable && pwrite && (idx == pbs_pkg::REG_BAR_WIDTH);
  assign pready = 1'b1;
  assign prdata = (idx == pbs_pkg::REG_BAR_WIDTH) ?
                  pbs_pkg::APB_DATA_W'(bar_q) : '0;

  // Reinit pulse comes in the cycle after the write, carrying the new width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_q    <= pbs_pkg::BAR_RESET;
      reinit_q <= 1'b0;
    end else begin
      reinit_q <= hit;
      if (hit) begin
        bar_q <= pwdata[pbs_pkg::WIDTH_BITS-1:0];
      end
    end
  end

  assign cfg_o.bar_width = bar_q;
  assign cfg_o.reinit    = reinit_q;

endmodule

>>> design/proportional_bar_smoother_core.sv
// Top level of the proportional bar smoother: sequencer, segment state, result register.
//
// The block holds a bar of bar_width pixels split into user, nice, sys, queue
// and idle segments. A sample transaction (op 0) sets each segment's target
// to count*bar_width/total (a zero total counts as one), with the last segment
// taking what the others leave; shown widths stay put. A tick transaction
// (op 1) moves every shown width one smoothing step toward its target. Each
// transaction yields one result carrying all shown widths after the step.
// A sample's result waits on the single bit-serial divider, which produces
// one quotient bit per cycle and is reused for each segment but the last in
// turn. A tick steps one segment per cycle through one smoothing unit. The
// next transaction is accepted in the cycle after the result is loaded into
// the output register, even while that result is still waiting to be taken.
// Writing bar_width (APB address 0) reinitializes all targets and shown
// widths to zero, except the last segment, which becomes the bar width;
// input is held off while this happens.
module proportional_bar_smoother_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pbs_in_if.sink                           sample_i,
  pbs_out_if.source                        result_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pbs_pkg::PADDR_W-1:0]      paddr,
  input  logic [pbs_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pbs_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int SNAP_GAP  = 2;
  localparam int STEP_GAP  = 255;
  localparam int AVG_SHIFT = 8;
  localparam int ACC_W     = pbs_pkg::WIDTH_BITS + AVG_SHIFT + 1;
  localparam int TSUM_W    = pbs_pkg::WIDTH_BITS + pbs_pkg::SEG_W;

  // One smoothing step: snap on a tiny gap, one pixel on a medium gap,
  // otherwise a 255:1 weighted average toward the goal.
  function automatic pbs_pkg::width_t smooth_step(pbs_pkg::width_t cur,
                                                  pbs_pkg::width_t goal);
    pbs_pkg::width_t gap;
    logic [ACC_W-1:0] acc;
    pbs_pkg::width_t res;
    gap = (cur > goal) ? (cur - goal) : (goal - cur);
    acc = (ACC_W'(cur) << AVG_SHIFT) - ACC_W'(cur) + ACC_W'(goal);
    if (ACC_W'(gap) < ACC_W'(SNAP_GAP)) begin
      res = goal;
    end else if (ACC_W'(gap) < ACC_W'(STEP_GAP)) begin
      res = (cur > goal) ? (cur - pbs_pkg::WIDTH_BITS'(1)) : (cur + pbs_pkg::WIDTH_BITS'(1));
    end else begin
      res = acc[pbs_pkg::WIDTH_BITS+AVG_SHIFT-1:AVG_SHIFT];
    end
    return res;
  endfunction

  pbs_pkg::cfg_t        cfg;
  pbs_pkg::div_stat_t   div_stat;
  pbs_pkg::width_t      quotient;

  pbs_pkg::state_e      state_q, state_d;
  logic [pbs_pkg::SEG_W-1:0] seg_q, seg_d;
  logic                 in_ready;
  logic                 in_accept;
  logic                 div_start;
  logic                 out_load;
  logic                 out_valid_q;

  pbs_pkg::width_t      target_q [pbs_pkg::SEGMENTS];
  pbs_pkg::width_t      shown_q  [pbs_pkg::SEGMENTS];
  pbs_pkg::width_t      shown_out_q [pbs_pkg::SEGMENTS];
  pbs_pkg::count_t      cnt_q    [pbs_pkg::SEGMENTS];
  logic [pbs_pkg::TOTAL_W-1:0] total_q;
  logic [pbs_pkg::TOTAL_W-1:0] count_sum;
  pbs_pkg::width_t      used_q;
  logic [pbs_pkg::PROD_W-1:0]  product;
  logic [TSUM_W-1:0]    target_sum;

  pbs_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Product of the selected count and the bar width feeds the divider's
  // load registers directly.
  assign product = pbs_pkg::PROD_W'(cnt_q[seg_q]) * pbs_pkg::PROD_W'(cfg.bar_width);

  pbs_div_serial u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (total_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_comb begin
    count_sum = '0;
    for (int i = 0; i < pbs_pkg::SEGMENTS; i++) begin
      count_sum = count_sum + pbs_pkg::TOTAL_W'(cnt_q[i]);
    end
  end

  always_comb begin
    target_sum = '0;
    for (int i = 0; i < pbs_pkg::SEGMENTS; i++) begin
      target_sum = target_sum + TSUM_W'(target_q[i]);
    end
  end

  assign in_accept = sample_i.valid && in_ready;

  // Sequencer: sample walks the divider over all segments but the last,
  // tick walks the smoothing unit over every segment.
  always_comb begin
    state_d   = state_q;
    seg_d     = seg_q;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      pbs_pkg::ST_IDLE: begin
        in_ready = !cfg.reinit;
        if (sample_i.valid && !cfg.reinit) begin
          seg_d   = '0;
          state_d = (pbs_pkg::op_e'(sample_i.op) == pbs_pkg::OP_TICK) ?
                    pbs_pkg::ST_TICK : pbs_pkg::ST_SUM;
        end
      end
      pbs_pkg::ST_SUM: begin
        state_d = pbs_pkg::ST_DIV_START;
      end
      pbs_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = pbs_pkg::ST_DIV_WAIT;
      end
      pbs_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (seg_q == pbs_pkg::SEG_W'(pbs_pkg::SEGMENTS - 2)) begin
            state_d = pbs_pkg::ST_LAST;
          end else begin
            seg_d   = seg_q + pbs_pkg::SEG_W'(1);
            state_d = pbs_pkg::ST_DIV_START;
          end
        end
      end
      pbs_pkg::ST_LAST: begin
        state_d = pbs_pkg::ST_FINISH;
      end
      pbs_pkg::ST_TICK: begin
        if (seg_q == pbs_pkg::SEG_W'(pbs_pkg::SEGMENTS - 1)) begin
          state_d = pbs_pkg::ST_FINISH;
        end else begin
          seg_d = seg_q + pbs_pkg::SEG_W'(1);
        end
      end
      pbs_pkg::ST_FINISH: begin
        // Hold until the result register is free, then load it.
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = pbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbs_pkg::ST_IDLE;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Segment state: reinit on a bar width write, otherwise at most one entry
  // updated per cycle, by the divider, the last-segment fill or the smoothing unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pbs_pkg::SEGMENTS; i++) begin
        target_q[i] <= '0;
        shown_q[i]  <= '0;
      end
      target_q[pbs_pkg::SEGMENTS-1] <= pbs_pkg::BAR_RESET;
      shown_q[pbs_pkg::SEGMENTS-1]  <= pbs_pkg::BAR_RESET;
    end else if (cfg.reinit) begin
      for (int i = 0; i < pbs_pkg::SEGMENTS; i++) begin
        target_q[i] <= '0;
        shown_q[i]  <= '0;
      end
      target_q[pbs_pkg::SEGMENTS-1] <= cfg.bar_width;
      shown_q[pbs_pkg::SEGMENTS-1]  <= cfg.bar_width;
    end else begin
      if (state_q == pbs_pkg::ST_DIV_WAIT && div_stat.done) begin
        target_q[seg_q] <= quotient;
      end
      if (state_q == pbs_pkg::ST_LAST) begin
        target_q[pbs_pkg::SEGMENTS-1] <= cfg.bar_width - used_q;
      end
      if (state_q == pbs_pkg::ST_TICK) begin
        shown_q[seg_q] <= smooth_step(shown_q[seg_q], target_q[seg_q]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cnt_q[0] <= sample_i.count_user;
      cnt_q[1] <= sample_i.count_nice;
      cnt_q[2] <= sample_i.count_sys;
      cnt_q[3] <= sample_i.count_queue;
      cnt_q[4] <= sample_i.count_idle;
    end
    if (state_q == pbs_pkg::ST_SUM) begin
      total_q <= (count_sum == '0) ? pbs_pkg::TOTAL_W'(1) : count_sum;
      used_q  <= '0;
    end
    if (state_q == pbs_pkg::ST_DIV_WAIT && div_stat.done) begin
      used_q <= used_q + quotient;
    end
    if (out_load) begin
      for (int i = 0; i < pbs_pkg::SEGMENTS; i++) begin
        shown_out_q[i] <= shown_q[i];
      end
    end
  end

  assign sample_i.ready       = in_ready;
  assign result_o.valid       = out_valid_q;
  assign result_o.shown_user  = shown_out_q[0];
  assign result_o.shown_nice  = shown_out_q[1];
  assign result_o.shown_sys   = shown_out_q[2];
  assign result_o.shown_queue = shown_out_q[3];
  assign result_o.shown_idle  = shown_out_q[4];

  // Divider is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbs_pkg::ST_DIV_START) |-> !div_stat.busy)
    else $error("divider started while busy");

  // A divider result only appears while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == pbs_pkg::ST_DIV_WAIT))
    else $error("divider result outside wait state");

  // At rest the targets always split the whole bar.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbs_pkg::ST_IDLE && !cfg.reinit) |->
      (target_sum == TSUM_W'(cfg.bar_width)))
    else $error("targets do not add up to bar width");

  // A new result is only raised from the finish state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == pbs_pkg::ST_FINISH))
    else $error("result raised outside finish state");

  // The last shown width never exceeds the bar.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg.reinit |-> (shown_q[pbs_pkg::SEGMENTS-1] <= cfg.bar_width))
    else $error("shown width beyond bar width");

endmodule
